### rtl/core/tksas_pkg.sv
// Package: shared types and constants of the top-k smallest arc selector.
`timescale 1ns / 1ps
`default_nettype none
package tksas_pkg;

  localparam int unsigned COST_W      = 24;
  localparam int unsigned INDEX_W     = 11;
  localparam int unsigned KEEP_W      = 6;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 24;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(8);
  localparam logic [COST_W-1:0] CEIL_RESET = COST_W'(1000000);

  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COST_CEILING = 1'b1;

  typedef struct packed {
    logic [COST_W-1:0]  arc_cost;
    logic [INDEX_W-1:0] item_index;
    logic               arc_infeasible;
    logic               line_last;
  } tksas_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] kept_index;
    logic               kept_valid;
    logic               result_last;
  } tksas_out_t;

  typedef struct packed {
    logic insert;
    logic capture;
    logic load_none;
    logic load_slot;
    logic advance;
    logic clear;
  } tksas_cmd_t;

  typedef struct packed {
    logic capture_empty;
    logic cur_hit;
    logic out_last;
  } tksas_status_t;

endpackage
`default_nettype wire

### rtl/core/tksas_datapath.sv
// Datapath: configuration registers, sorted slot chain, emit mask and result register.
`timescale 1ns / 1ps
`default_nettype none
module tksas_datapath import tksas_pkg::*; #(
  parameter int unsigned MAX_KEEP = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire tksas_in_t             in_data_i,
  input  wire tksas_cmd_t            cmd_i,
  output tksas_status_t              status_o,
  output tksas_out_t                 out_data_o
);

  localparam int unsigned PTR_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int unsigned KW    = KEEP_W + 1;

  logic [KEEP_W-1:0]  keep_count_q;
  logic [COST_W-1:0]  cost_ceiling_q;

  logic [COST_W-1:0]  slot_cost_q  [MAX_KEEP];
  logic [INDEX_W-1:0] slot_index_q [MAX_KEEP];
  logic [MAX_KEEP-1:0] slot_filled_q;

  logic [COST_W-1:0]  slot_cost_d  [MAX_KEEP];
  logic [INDEX_W-1:0] slot_index_d [MAX_KEEP];
  logic [MAX_KEEP-1:0] slot_filled_d;

  logic [COST_W-1:0]  prev_cost  [MAX_KEEP];
  logic [INDEX_W-1:0] prev_index [MAX_KEEP];
  logic [MAX_KEEP-1:0] prev_filled;

  logic [MAX_KEEP-1:0] mask_q, mask_d;
  logic [MAX_KEEP-1:0] rest;
  logic [PTR_W-1:0]    ptr_q, ptr_d;
  tksas_out_t          out_q, out_d;

  logic [KW-1:0]       kc;
  logic [KW-1:0]       k_eff;
  logic [MAX_KEEP-1:0] active;
  logic [MAX_KEEP-1:0] hit;
  logic [MAX_KEEP-1:0] hit_above;
  logic                prior;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_count_q   <= KEEP_RESET;
      cost_ceiling_q <= CEIL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_KEEP_COUNT:   keep_count_q   <= cfg_data_i[KEEP_W-1:0];
        REG_COST_CEILING: cost_ceiling_q <= cfg_data_i[COST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    kc = {1'b0, keep_count_q};
    if (kc == '0) begin
      k_eff = KW'(1);
    end else if (kc > KW'(MAX_KEEP)) begin
      k_eff = KW'(MAX_KEEP);
    end else begin
      k_eff = kc;
    end
  end

  always_comb begin
    prior = 1'b0;
    for (int s = 0; s < MAX_KEEP; s++) begin
      active[s]    = (KW'(s) < k_eff);
      hit[s]       = active[s] && !in_data_i.arc_infeasible &&
                     (in_data_i.arc_cost <= slot_cost_q[s]);
      hit_above[s] = prior;
      prior        = prior | hit[s];
    end
  end

  always_comb begin
    prev_cost[0]   = '0;
    prev_index[0]  = '0;
    prev_filled[0] = 1'b0;
    for (int s = 1; s < MAX_KEEP; s++) begin
      prev_cost[s]   = slot_cost_q[s-1];
      prev_index[s]  = slot_index_q[s-1];
      prev_filled[s] = slot_filled_q[s-1];
    end
  end

  always_comb begin
    for (int s = 0; s < MAX_KEEP; s++) begin
      slot_cost_d[s]   = slot_cost_q[s];
      slot_index_d[s]  = slot_index_q[s];
      slot_filled_d[s] = slot_filled_q[s];
      if (cmd_i.clear) begin
        slot_cost_d[s]   = cost_ceiling_q;
        slot_index_d[s]  = '0;
        slot_filled_d[s] = 1'b0;
      end else if (cmd_i.insert && active[s] && hit_above[s]) begin
        slot_cost_d[s]   = prev_cost[s];
        slot_index_d[s]  = prev_index[s];
        slot_filled_d[s] = prev_filled[s];
      end else if (cmd_i.insert && hit[s]) begin
        slot_cost_d[s]   = in_data_i.arc_cost;
        slot_index_d[s]  = in_data_i.item_index;
        slot_filled_d[s] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_filled_q <= '0;
      for (int s = 0; s < MAX_KEEP; s++) begin
        slot_cost_q[s] <= CEIL_RESET;
      end
    end else begin
      slot_filled_q <= slot_filled_d;
      for (int s = 0; s < MAX_KEEP; s++) begin
        slot_cost_q[s] <= slot_cost_d[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < MAX_KEEP; s++) begin
      slot_index_q[s] <= slot_index_d[s];
    end
  end

  always_comb begin
    rest        = mask_q;
    rest[ptr_q] = 1'b0;
  end

  always_comb begin
    mask_d = mask_q;
    ptr_d  = ptr_q;
    out_d  = out_q;
    if (cmd_i.capture) begin
      mask_d = slot_filled_q & active;
      ptr_d  = '0;
    end
    if (cmd_i.load_none) begin
      out_d.kept_index  = '0;
      out_d.kept_valid  = 1'b0;
      out_d.result_last = 1'b1;
    end
    if (cmd_i.load_slot) begin
      out_d.kept_index  = slot_index_q[ptr_q];
      out_d.kept_valid  = 1'b1;
      out_d.result_last = (rest == '0);
      mask_d            = rest;
    end
    if (cmd_i.advance) begin
      ptr_d = ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      ptr_q  <= '0;
    end else begin
      mask_q <= mask_d;
      ptr_q  <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign status_o.capture_empty = ((slot_filled_q & active) == '0);
  assign status_o.cur_hit       = mask_q[ptr_q];
  assign status_o.out_last      = out_q.result_last;
  assign out_data_o             = out_q;

endmodule
`default_nettype wire

### rtl/core/tksas_ctrl.sv
// Controller: state machine sequencing insertion, line-end scan and result transfers.
`timescale 1ns / 1ps
`default_nettype none
module tksas_ctrl import tksas_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_line_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire tksas_status_t status_i,
  output tksas_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_CAPTURE = 4'b0010,
    S_SEEK    = 4'b0100,
    S_OUT     = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.insert = 1'b1;
          if (in_line_last_i) begin
            state_d = S_CAPTURE;
          end
        end
      end
      S_CAPTURE: begin
        cmd_o.capture = 1'b1;
        if (status_i.capture_empty) begin
          cmd_o.load_none = 1'b1;
          state_d         = S_OUT;
        end else begin
          state_d = S_SEEK;
        end
      end
      S_SEEK: begin
        if (status_i.cur_hit) begin
          cmd_o.load_slot = 1'b1;
          state_d         = S_OUT;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.out_last) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = S_SEEK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/top_k_smallest_arc_selector.sv
// Top level: streaming selector of the k smallest feasible costs of one matrix line.
// On each input transfer the cost is compared against all active slots at
// once and the sorted slot chain shifts in the same cycle. After the
// transfer that ends a line is inserted, the block captures the kept
// slots, scans the slots up to the highest kept slot (at most k), hands out
// one result per kept slot (or one empty result if none is kept), holding
// each through any output stall, and reloads every slot with the cost
// ceiling on the final result transfer. Input is not taken while results
// of a line are pending. The slot compare chain sets the critical path:
// one 24-bit compare per slot and a priority prefix over MAX_KEEP slots.
`timescale 1ns / 1ps
`default_nettype none
module top_k_smallest_arc_selector import tksas_pkg::*; #(
  parameter int unsigned MAX_KEEP = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire tksas_in_t             in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output tksas_out_t                 out_data_o
);

  tksas_cmd_t    cmd;
  tksas_status_t status;

  tksas_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_line_last_i (in_data_i.line_last),
    .in_ready_o     (in_ready_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  tksas_datapath #(
    .MAX_KEEP (MAX_KEEP)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

### rtl/core/tksas_checker.sv
// Checker: port-level assertions for the top-k smallest arc selector, with bind.
`timescale 1ns / 1ps
`default_nettype none
module tksas_checker import tksas_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire tksas_in_t  in_data_i,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire tksas_out_t out_data_o
);

  a_no_input_while_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)
  ) else $error("input ready while a result is pending");

  a_output_holds: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o)
  ) else $error("stalled result changed");

  a_none_is_last: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.kept_valid |->
      out_data_o.result_last && (out_data_o.kept_index == '0)
  ) else $error("empty-line result malformed");

  a_line_end_yields_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.line_last |=> !in_ready_o
  ) else $error("input taken right after a line end");

endmodule

bind top_k_smallest_arc_selector tksas_checker u_tksas_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
